// ===== design/xor_frame_parser_macros.svh =====
// Assertion helpers for the frame parser.
`ifndef XOR_FRAME_PARSER_MACROS_SVH
`define XOR_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define XFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define XFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/xfp_pkg.sv =====
`timescale 1ns / 1ps

package xfp_pkg;

    localparam logic [7:0] HEADER_MARK    = 8'hAA;
    localparam int         FRAME_OVERHEAD = 8;
    localparam int         PAYLOAD_START  = 7;
    localparam logic [8:0] POS_MAX        = 9'd511;
    localparam int         ADDR_W         = 4;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_HEADER   = 3'd1,
        ST_COMMAND  = 3'd2,
        ST_RANGE    = 3'd3,
        ST_LENGTH   = 3'd4,
        ST_CHECKSUM = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_WRITE_CODE = 2'd0,
        REG_READ_CODE  = 2'd1,
        REG_REPLY_CODE = 2'd2
    } reg_idx_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_packet;
    } rx_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        status_t     status;
        logic [7:0]  command;
        logic [7:0]  start_offset;
        logic [7:0]  payload_len;
        logic [31:0] good_count;
        logic [31:0] bad_count;
    } res_item_t;

endpackage

// ===== design/xfp_if.sv =====
`timescale 1ns / 1ps

interface xfp_rx_if;
    logic               valid;
    logic               ready;
    xfp_pkg::rx_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface xfp_res_if;
    logic               valid;
    logic               ready;
    xfp_pkg::res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/xor_frame_parser.sv =====
`timescale 1ns / 1ps
`include "xor_frame_parser_macros.svh"

// Path: a byte accepted lands in the input register, is checked there, and its result
// (if any) is shown from the output register.
// Throughput: one byte per cycle while results are taken; the output register is the
// only thing that stalls the input register.
// Reset (rst_n low, asynchronous): codes return to 1/2/3, frame state and both packet
// counters clear to zero, both pipeline registers empty.
module xor_frame_parser #(
    parameter int TABLE_BYTES = 128
) (
    input  logic                       clk,
    input  logic                       rst_n,
    xfp_rx_if.sink                     rx,
    xfp_res_if.source                  res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [xfp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import xfp_pkg::*;

    localparam logic [9:0] TableLim = 10'(TABLE_BYTES);

    // configuration
    logic [7:0] write_code_reg, read_code_reg, reply_code_reg;
    logic       cfg_wr;
    reg_idx_t   cfg_idx;

    // input register
    logic       s1_valid_reg;
    rx_item_t   s1_item_reg;
    logic       s1_fire;

    // frame state
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    status_t     err_reg, err_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  off_reg, off_next;
    logic [7:0]  len_reg, len_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] bad_reg, bad_next;

    // output register
    logic       out_valid_reg;
    res_item_t  out_item_reg, out_item_next;
    logic       out_load;

    logic       out_free;
    logic [7:0] b;
    logic       last;
    status_t    err_found;
    status_t    verdict;
    logic       in_payload;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_WRITE_CODE: prdata = {24'd0, write_code_reg};
            REG_READ_CODE:  prdata = {24'd0, read_code_reg};
            REG_REPLY_CODE: prdata = {24'd0, reply_code_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_code_reg <= 8'd1;
            read_code_reg  <= 8'd2;
            reply_code_reg <= 8'd3;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_WRITE_CODE: write_code_reg <= pwdata[7:0];
                REG_READ_CODE:  read_code_reg  <= pwdata[7:0];
                REG_REPLY_CODE: reply_code_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Handshake: the input register moves on whenever the output slot is free.
    assign out_free  = !out_valid_reg || res.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign rx.ready  = !s1_valid_reg || s1_fire;
    assign res.valid = out_valid_reg;
    assign res.data  = out_item_reg;

    assign b    = s1_item_reg.rx_byte;
    assign last = s1_item_reg.end_of_packet;

    always_comb
    begin
        cmd_next = cmd_reg;
        off_next = off_reg;
        len_next = len_reg;
        err_found = ST_OK;

        if (pos_reg <= 9'd3)
        begin
            if (b != HEADER_MARK)
                err_found = ST_HEADER;
        end
        else if (pos_reg == 9'd4)
        begin
            cmd_next = b;
            if (b != write_code_reg && b != read_code_reg && b != reply_code_reg)
                err_found = ST_COMMAND;
        end
        else if (pos_reg == 9'd5)
        begin
            off_next = b;
        end
        else if (pos_reg == 9'd6)
        begin
            len_next = b;
            if (({2'b0, off_reg} + {2'b0, b}) > TableLim)
                err_found = ST_RANGE;
        end

        // end-of-frame checks come after the field checks in priority
        if (last && err_found == ST_OK)
        begin
            if (({1'b0, pos_reg} + 10'd1) != ({2'b0, len_next} + 10'(FRAME_OVERHEAD)))
                err_found = ST_LENGTH;
            else if (xor_reg != b)
                err_found = ST_CHECKSUM;
        end

        verdict = (err_reg != ST_OK) ? err_reg : err_found;

        in_payload = (pos_reg >= 9'(PAYLOAD_START))
                  && ({1'b0, pos_reg} < (10'(PAYLOAD_START) + {2'b0, len_reg}));

        pos_next  = pos_reg;
        xor_next  = xor_reg;
        err_next  = verdict;
        good_next = good_reg;
        bad_next  = bad_reg;
        out_load  = 1'b0;

        out_item_next              = out_item_reg;
        out_item_next.command      = cmd_next;
        out_item_next.start_offset = off_next;
        out_item_next.payload_len  = len_next;

        if (last)
        begin
            if (verdict == ST_OK)
                good_next = good_reg + 32'd1;
            else
                bad_next = bad_reg + 32'd1;
            out_load                 = 1'b1;
            out_item_next.kind       = KIND_VERDICT;
            out_item_next.data_byte  = 8'd0;
            out_item_next.data_index = 8'd0;
            out_item_next.status     = verdict;
            out_item_next.good_count = good_next;
            out_item_next.bad_count  = bad_next;
            pos_next = 9'd0;
            xor_next = 8'd0;
            err_next = ST_OK;
            cmd_next = 8'd0;
            off_next = 8'd0;
            len_next = 8'd0;
        end
        else
        begin
            xor_next = xor_reg ^ b;
            if (pos_reg < POS_MAX)
                pos_next = pos_reg + 9'd1;
            out_load                 = in_payload;
            out_item_next.kind       = KIND_PAYLOAD;
            out_item_next.data_byte  = b;
            out_item_next.data_index = 8'(pos_reg - 9'(PAYLOAD_START));
            out_item_next.status     = ST_OK;
            out_item_next.good_count = good_reg;
            out_item_next.bad_count  = bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg  <= '0;
            xor_reg  <= '0;
            err_reg  <= ST_OK;
            cmd_reg  <= '0;
            off_reg  <= '0;
            len_reg  <= '0;
            good_reg <= '0;
            bad_reg  <= '0;
        end
        else
        begin
            if (rx.ready)
                s1_valid_reg <= rx.valid;
            if (s1_fire)
                out_valid_reg <= out_load;
            else if (res.ready)
                out_valid_reg <= 1'b0;
            if (s1_fire)
            begin
                pos_reg  <= pos_next;
                xor_reg  <= xor_next;
                err_reg  <= err_next;
                cmd_reg  <= cmd_next;
                off_reg  <= off_next;
                len_reg  <= len_next;
                good_reg <= good_next;
                bad_reg  <= bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            s1_item_reg <= rx.data;
        if (s1_fire && out_load)
            out_item_reg <= out_item_next;
    end

    `XFP_ASSERT_NEXT(a_frame_cleared, s1_fire && last, pos_reg == 9'd0 && err_reg == ST_OK, "frame state not cleared after end beat")
    `XFP_ASSERT_NEXT(a_one_counter, s1_fire && last, (good_reg != $past(good_reg)) != (bad_reg != $past(bad_reg)), "verdict must bump exactly one counter")
    `XFP_ASSERT_NOW(a_verdict_data_zero, out_valid_reg && out_item_reg.kind == KIND_VERDICT, out_item_reg.data_byte == 8'd0 && out_item_reg.data_index == 8'd0, "verdict carries payload data")
    `XFP_ASSERT_NOW(a_payload_ok, out_valid_reg && out_item_reg.kind == KIND_PAYLOAD, out_item_reg.status == ST_OK, "payload beat with nonzero status")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import xfp_pkg::*;

    localparam int TABLE_BYTES  = 128;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 110;
    localparam int REG_SPARE    = 3;   // decoded address past the last code register

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    logic     rx_valid  = 1'b0;
    rx_item_t rx_data   = '0;
    logic     res_ready = 1'b0;

    xfp_rx_if  rx_if ();
    xfp_res_if res_if ();

    assign rx_if.valid  = rx_valid;
    assign rx_if.data   = rx_data;
    assign res_if.ready = res_ready;

    xor_frame_parser #(.TABLE_BYTES(TABLE_BYTES)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Parser shadow: command codes and per-frame state.
    logic [7:0]  code_wr     = 8'd1;
    logic [7:0]  code_rd     = 8'd2;
    logic [7:0]  code_rp     = 8'd3;
    logic [8:0]  frame_pos   = '0;
    logic [7:0]  frame_xor   = '0;
    status_t     frame_err   = ST_OK;
    logic [7:0]  frame_cmd   = '0;
    logic [7:0]  frame_off   = '0;
    logic [7:0]  frame_len   = '0;
    logic [31:0] good_total  = '0;
    logic [31:0] bad_total   = '0;

    rx_item_t  rx_bytes_q [$];
    res_item_t parsed_beats [$];

    int errors        = 0;
    int src_gap       = 0;
    int stall_left    = 0;
    int hold_left     = 0;
    int hold_asks     = 0;
    int hold_done     = 0;
    int idle_cycles   = 0;
    bit src_bursty    = 1'b0;
    bit res_bursty    = 1'b0;
    int bytes_queued  = 0;
    int frames_queued = 0;
    int cfg_writes    = 0;
    int payload_seen  = 0;
    int verdict_hist [6];

    function automatic void flag_error(status_t code);
        if (frame_err == ST_OK)
            frame_err = code;
    endfunction

    function automatic void parse_rx_byte(rx_item_t it);
        logic [8:0] pos;
        res_item_t  r;
        pos = frame_pos;
        r   = '0;
        if (pos <= 9'd3)
        begin
            if (it.rx_byte != HEADER_MARK)
                flag_error(ST_HEADER);
        end
        else if (pos == 9'd4)
        begin
            frame_cmd = it.rx_byte;
            if (it.rx_byte != code_wr && it.rx_byte != code_rd && it.rx_byte != code_rp)
                flag_error(ST_COMMAND);
        end
        else if (pos == 9'd5)
            frame_off = it.rx_byte;
        else if (pos == 9'd6)
        begin
            frame_len = it.rx_byte;
            if (int'(frame_off) + int'(frame_len) > TABLE_BYTES)
                flag_error(ST_RANGE);
        end

        r.command      = frame_cmd;
        r.start_offset = frame_off;
        r.payload_len  = frame_len;
        if (it.end_of_packet)
        begin
            if (int'(pos) + 1 != int'(frame_len) + FRAME_OVERHEAD)
                flag_error(ST_LENGTH);
            if (frame_xor != it.rx_byte)
                flag_error(ST_CHECKSUM);
            if (frame_err == ST_OK)
                good_total = good_total + 32'd1;
            else
                bad_total = bad_total + 32'd1;
            r.kind       = KIND_VERDICT;
            r.status     = frame_err;
            r.good_count = good_total;
            r.bad_count  = bad_total;
            parsed_beats.push_back(r);
            frame_pos = '0;
            frame_xor = '0;
            frame_err = ST_OK;
            frame_cmd = '0;
            frame_off = '0;
            frame_len = '0;
        end
        else
        begin
            frame_xor = frame_xor ^ it.rx_byte;
            if (frame_pos < POS_MAX)
                frame_pos = frame_pos + 9'd1;
            if (int'(pos) >= PAYLOAD_START && int'(pos) < PAYLOAD_START + int'(frame_len))
            begin
                r.kind       = KIND_PAYLOAD;
                r.data_byte  = it.rx_byte;
                r.data_index = 8'(int'(pos) - PAYLOAD_START);
                r.status     = ST_OK;
                r.good_count = good_total;
                r.bad_count  = bad_total;
                parsed_beats.push_back(r);
            end
        end
    endfunction

    function automatic string fmt_res(res_item_t r);
        return {$sformatf("kind=%0d byte=%02h idx=%0d st=%0d ",
                          r.kind, r.data_byte, r.data_index, r.status),
                $sformatf("cmd=%02h off=%02h len=%02h good=%0d bad=%0d",
                          r.command, r.start_offset, r.payload_len,
                          r.good_count, r.bad_count)};
    endfunction

    function automatic void note_error(string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function automatic void check_result(res_item_t got);
        res_item_t want;
        if (parsed_beats.size() == 0)
        begin
            note_error({"unexpected beat ", fmt_res(got)});
            return;
        end
        want = parsed_beats.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte
            || got.data_index !== want.data_index || got.status !== want.status
            || got.command !== want.command || got.start_offset !== want.start_offset
            || got.payload_len !== want.payload_len || got.good_count !== want.good_count
            || got.bad_count !== want.bad_count)
            note_error({"want ", fmt_res(want), " got ", fmt_res(got)});
        if (want.kind == KIND_PAYLOAD)
            payload_seen++;
        else
            verdict_hist[int'(want.status)]++;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3))
                                           : int'($urandom_range(8, 40));
    endfunction

    // Byte source
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            src_gap  <= 0;
        end
        else
        begin
            if (rx_valid && rx_if.ready)
                parse_rx_byte(rx_data);
            if (!rx_valid || rx_if.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap  <= src_gap - 1;
                    rx_valid <= 1'b0;
                end
                else if (rx_bytes_q.size() > 0)
                begin
                    rx_data  <= rx_bytes_q.pop_front();
                    rx_valid <= 1'b1;
                    src_gap  <= (src_bursty && $urandom_range(0, 3) == 0) ? gap_len() : 0;
                end
                else
                    rx_valid <= 1'b0;
            end
        end
    end

    // Result sink
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_ready)
                check_result(res_if.data);
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                res_ready <= 1'b0;
            end
            else if (hold_done != hold_asks)
            begin
                hold_done <= hold_asks;
                hold_left <= HOLD_CYCLES - 1;
                res_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                res_ready  <= 1'b0;
            end
            else if (res_bursty && $urandom_range(0, 4) == 0)
            begin
                stall_left <= gap_len() - 1;
                res_ready  <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (rx_valid && rx_if.ready) || (res_if.valid && res_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[%0t] no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("** xor_frame_parser: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic csr_write(int idx, logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= {24'($urandom), val};   // upper bits are don't-care
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
        case (idx)
            int'(REG_WRITE_CODE): code_wr = val;
            int'(REG_READ_CODE):  code_rd = val;
            int'(REG_REPLY_CODE): code_rp = val;
            default: ;
        endcase
    endtask

    task automatic csr_check(int idx, logic [7:0] want);
        logic [7:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(4 * idx);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata[7:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            note_error($sformatf("register %0d reads %02h, want %02h", idx, got, want));
    endtask

    task automatic check_codes();
        csr_check(int'(REG_WRITE_CODE), code_wr);
        csr_check(int'(REG_READ_CODE), code_rd);
        csr_check(int'(REG_REPLY_CODE), code_rp);
    endtask

    task automatic set_codes(logic [7:0] w, logic [7:0] r, logic [7:0] p);
        csr_write(int'(REG_WRITE_CODE), w);
        csr_write(int'(REG_READ_CODE), r);
        csr_write(int'(REG_REPLY_CODE), p);
        check_codes();
    endtask

    // Wait until every queued byte has been sent and every result has drained, plus pipeline slack.
    task automatic wait_idle();
        while (rx_bytes_q.size() != 0 || rx_valid || parsed_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_bytes(ref logic [7:0] bytes [$]);
        rx_item_t it;
        foreach (bytes[i])
        begin
            it.rx_byte       = bytes[i];
            it.end_of_packet = (i == bytes.size() - 1);
            rx_bytes_q.push_back(it);
        end
        bytes_queued += bytes.size();
        frames_queued++;
    endtask

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 2))
            0:       return code_wr;
            1:       return code_rd;
            default: return code_rp;
        endcase
    endfunction

    function automatic logic [7:0] not_aa();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 255));
        while (v == HEADER_MARK);
        return v;
    endfunction

    // hdr_hit < 0 keeps the header intact; body_delta moves the end mark.
    task automatic queue_frame(logic [7:0] cmd, logic [7:0] off, logic [7:0] len,
                               int hdr_hit, int body_delta, logic [7:0] sum_flip);
        logic [7:0] bytes [$];
        logic [7:0] sum;
        int         body;
        repeat (4) bytes.push_back(HEADER_MARK);
        if (hdr_hit >= 0)
            bytes[hdr_hit] = not_aa();
        bytes.push_back(cmd);
        bytes.push_back(off);
        bytes.push_back(len);
        body = int'(len) + body_delta;
        if (body < 0)
            body = 0;
        repeat (body) bytes.push_back(8'($urandom_range(0, 255)));
        sum = '0;
        foreach (bytes[i])
            sum = sum ^ bytes[i];
        bytes.push_back(sum ^ sum_flip);
        send_bytes(bytes);
    endtask

    // Frame cut off somewhere in the first seven bytes.
    task automatic queue_short(int n);
        logic [7:0] bytes [$];
        for (int i = 0; i < n; i++)
        begin
            if (i < 4)
                bytes.push_back(($urandom_range(0, 9) == 0) ? not_aa() : HEADER_MARK);
            else if (i == 4)
                bytes.push_back(pick_code());
            else
                bytes.push_back(8'($urandom_range(0, 255)));
        end
        send_bytes(bytes);
    endtask

    task automatic queue_noise();
        logic [7:0] bytes [$];
        repeat ($urandom_range(1, 24)) bytes.push_back(8'($urandom_range(0, 255)));
        send_bytes(bytes);
    endtask

    task automatic queue_random_frame();
        int         pick;
        int         delta;
        logic [7:0] cmd;
        logic [7:0] off;
        logic [7:0] len;
        pick = $urandom_range(0, 99);
        cmd  = pick_code();
        len  = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 128) : $urandom_range(0, 12));
        off  = 8'($urandom_range(0, TABLE_BYTES - int'(len)));
        if (pick < 55)
            queue_frame(cmd, off, len, -1, 0, 8'h00);
        else if (pick < 61)
            queue_frame(cmd, off, len, $urandom_range(0, 3), 0, 8'h00);
        else if (pick < 67)
        begin
            do
                cmd = 8'($urandom_range(0, 255));
            while (cmd == code_wr || cmd == code_rd || cmd == code_rp);
            queue_frame(cmd, off, len, -1, 0, 8'h00);
        end
        else if (pick < 73)
        begin
            // offset + length past the table; long bodies get cut short
            len   = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 20));
            off   = 8'($urandom_range(TABLE_BYTES + 1 - int'(len), 255));
            delta = (len > 8'd20) ? $urandom_range(0, 8) - int'(len) : 0;
            queue_frame(cmd, off, len, -1, delta, 8'h00);
        end
        else if (pick < 79)
        begin
            delta = $urandom_range(1, 3);
            if ($urandom_range(0, 1) == 1 && int'(len) >= delta)
                delta = -delta;
            queue_frame(cmd, off, len, -1, delta, 8'h00);
        end
        else if (pick < 85)
            queue_frame(cmd, off, len, -1, 0, 8'($urandom_range(1, 255)));
        else if (pick < 93)
            queue_short($urandom_range(1, 7));
        else
            queue_noise();
    endtask

    task automatic fill_phase(int quota);
        int mark;
        mark = bytes_queued + quota;
        while (bytes_queued < mark)
            queue_random_frame();
    endtask

    initial
    begin
        logic [7:0] v;
        logic [7:0] single [$];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_codes();

        // Directed: table edge, range overflow, one-byte frame, broken header.
        @(negedge clk);
        queue_frame(code_rp, 8'd128, 8'd0, -1, 0, 8'h00);
        queue_frame(code_rd, 8'd127, 8'd2, -1, 0, 8'h00);
        single.push_back(HEADER_MARK);
        send_bytes(single);
        queue_frame(code_wr, 8'd0, 8'd0, 0, 0, 8'h00);
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    @(negedge clk);
                    src_bursty = 1'b1;
                    res_bursty = 1'b1;
                    fill_phase(PHASE_BYTES);
                end
                1:
                begin
                    set_codes(8'h00, 8'hFF, HEADER_MARK);
                    @(negedge clk);
                    src_bursty = 1'b0;
                    res_bursty = 1'b0;
                    // long sink hold while the source keeps offering
                    hold_asks++;
                    queue_frame(8'h00, 8'd0, 8'd128, -1, 0, 8'h00);
                    fill_phase(PHASE_BYTES);
                end
                2:
                begin
                    v = 8'($urandom_range(0, 255));
                    set_codes(v, v, v);
                    csr_write(REG_SPARE, 8'($urandom_range(0, 255)));
                    check_codes();
                    @(negedge clk);
                    src_bursty = 1'b1;
                    res_bursty = 1'b1;
                    fill_phase(PHASE_BYTES / 2);
                    wait_idle();
                    fill_phase(PHASE_BYTES / 2);
                end
                default:
                begin
                    set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                    @(negedge clk);
                    src_bursty = 1'b0;
                    res_bursty = 1'b1;
                    fill_phase(PHASE_BYTES / 2);
                    // runs past the saturation point of the byte counter
                    queue_frame(pick_code(), 8'd0, 8'd8, -1, 510, 8'h00);
                    fill_phase(PHASE_BYTES / 2);
                end
            endcase
            wait_idle();
        end

        $display("run: %0d bytes in %0d frames, %0d payload beats, %0d register writes",
                 bytes_queued, frames_queued, payload_seen, cfg_writes);
        $display("verdicts ok/header/command/range/length/checksum: %0d/%0d/%0d/%0d/%0d/%0d",
                 verdict_hist[0], verdict_hist[1], verdict_hist[2],
                 verdict_hist[3], verdict_hist[4], verdict_hist[5]);
        if (errors == 0)
            $display("** xor_frame_parser: PASSED **");
        else
            $display("** xor_frame_parser: FAILED **");
        $finish;
    end

endmodule
